// ===== rtl/mnva_pkg.sv =====
// Shared types and constants for the MIDI note voice allocator.
package mnva_pkg;

  localparam int MOTOR_COUNT = 8;
  localparam int MOTOR_IDX_W = 3;

  localparam logic [7:0] MOTOR_OFF     = 8'hFF;
  localparam logic [3:0] NOTE_ON_CODE  = 4'h9;
  localparam logic [3:0] NOTE_OFF_CODE = 4'h8;

  localparam logic [1:0] CFG_MAPPING_MODE = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_MAP  = 2'd1;
  localparam logic [1:0] CFG_PITCH_OFFSET = 2'd2;
  localparam logic [1:0] CFG_IGNORED_BYTE = 2'd3;

  localparam logic [23:0] CHANNEL_MAP_RESET  = 24'd2396160;
  localparam logic [6:0]  PITCH_OFFSET_RESET = 7'd21;
  localparam logic [7:0]  IGNORED_BYTE_RESET = 8'd254;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_ON    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    POS_STATUS = 2'd0,
    POS_KEY    = 2'd1,
    POS_VEL    = 2'd2
  } byte_pos_t;

  typedef enum logic [1:0] {
    ENG_IDLE  = 2'd0,
    ENG_READ  = 2'd1,
    ENG_CHECK = 2'd2
  } eng_state_t;

  // Complete event handed from the byte parser to the motor walk.
  typedef struct packed {
    logic                   mapping;
    kind_t                  kind;
    logic                   vel_nz;
    logic [7:0]             key;
    logic [7:0]             pitch;
    logic [MOTOR_COUNT-1:0] match;
  } evt_t;

endpackage

// ===== rtl/mnva_engine.sv =====
// Motor walk: note table memory, read-modify-write per motor, output register.
module mnva_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  mnva_pkg::evt_t                 evt,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     motor_pitch,
  output logic [mnva_pkg::MOTOR_IDX_W-1:0] motor_index,
  output logic                           last_update
);
  import mnva_pkg::*;

  eng_state_t state, state_next;
  logic [MOTOR_IDX_W-1:0] idx;
  evt_t evt_r;

  logic [7:0] notes_mem [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] note_written;
  logic [7:0] rd_q;
  logic       rd_q_written;

  logic [7:0] note;
  logic alloc_on, alloc_off, hit, final_hit, out_free, fire, advance, walk_end;
  logic [7:0] wr_data, pitch_out;

  // Any matching motor above the current one in mapping mode.
  always_comb begin
    final_hit = 1'b1;
    for (int j = 0; j < MOTOR_COUNT; j++) begin
      if (evt_r.mapping && (j > int'(idx)) && evt_r.match[j]) final_hit = 1'b0;
    end
  end

  always_comb begin
    note      = rd_q_written ? rd_q : MOTOR_OFF;
    alloc_on  = !evt_r.mapping && (evt_r.kind == KIND_ON) && evt_r.vel_nz;
    alloc_off = !evt_r.mapping && ((evt_r.kind == KIND_OFF) ||
                ((evt_r.kind == KIND_ON) && !evt_r.vel_nz));
    if (alloc_on)       hit = (note == MOTOR_OFF);
    else if (alloc_off) hit = (note == evt_r.key);
    else                hit = evt_r.mapping && evt_r.match[idx];
    wr_data   = alloc_off ? MOTOR_OFF : evt_r.key;
    pitch_out = (alloc_off || (evt_r.mapping && (evt_r.kind == KIND_OFF))) ?
                MOTOR_OFF : evt_r.pitch;
    out_free  = !out_valid || !out_stall;
    fire      = (state == ENG_CHECK) && hit && out_free;
    advance   = (state == ENG_CHECK) && (!hit || out_free);
    walk_end  = (hit && final_hit) || (idx == MOTOR_IDX_W'(MOTOR_COUNT - 1));
  end

  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE:  if (start) state_next = ENG_READ;
      ENG_READ:  state_next = ENG_CHECK;
      ENG_CHECK: if (advance) state_next = walk_end ? ENG_IDLE : ENG_READ;
      default:   state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ENG_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ENG_IDLE;
      out_valid    <= 1'b0;
      note_written <= '0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid           <= 1'b1;
        note_written[idx]   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Note table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (fire) notes_mem[idx] <= wr_data;
    if (state == ENG_READ) begin
      rd_q         <= notes_mem[idx];
      rd_q_written <= note_written[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state == ENG_IDLE)) begin
      evt_r <= evt;
      idx   <= '0;
    end else if (advance && !walk_end) begin
      idx <= idx + MOTOR_IDX_W'(1);
    end
    if (fire) begin
      motor_pitch <= pitch_out;
      motor_index <= idx;
      last_update <= final_hit;
    end
  end

endmodule

// ===== rtl/midi_note_voice_allocator_top.sv =====
// Top level: config registers, MIDI byte assembly and the motor walk engine.
// Each motor walked takes a read state, then a check/write state; the update for
// motor k is registered in motor k's check state, after the final byte's accept.
// Input: status, key and filler bytes are taken while the engine is idle; a final
// byte raises in_stall until its walk ends, which an output stall can prolong.
// Reset: config to defaults, assembly to the status byte, every motor off.
module midi_note_voice_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [23:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       midi_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       motor_pitch,
  output logic [mnva_pkg::MOTOR_IDX_W-1:0] motor_index,
  output logic                             last_update
);
  import mnva_pkg::*;

  // Configuration registers.
  logic        mapping_mode;
  logic [23:0] channel_map;
  logic [6:0]  pitch_offset;
  logic [7:0]  ignored_byte;

  // Event assembly state.
  byte_pos_t  byte_position;
  kind_t      event_kind;
  logic [3:0] event_channel;
  logic [7:0] event_key;

  logic   in_take, is_note, is_on_status, is_off_status, start, eng_busy;
  evt_t   evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_mode <= 1'b0;
      channel_map  <= CHANNEL_MAP_RESET;
      pitch_offset <= PITCH_OFFSET_RESET;
      ignored_byte <= IGNORED_BYTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAPPING_MODE: mapping_mode <= cfg_data[0];
        CFG_CHANNEL_MAP:  channel_map  <= cfg_data;
        CFG_PITCH_OFFSET: pitch_offset <= cfg_data[6:0];
        CFG_IGNORED_BYTE: ignored_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The engine owns the note table, so bytes wait while it walks.
  assign in_stall = eng_busy;
  // Filler bytes are consumed and dropped right here.
  assign in_take  = in_valid && !in_stall && (midi_byte != ignored_byte);

  assign is_on_status  = (midi_byte[7:4] == NOTE_ON_CODE);
  assign is_off_status = (midi_byte[7:4] == NOTE_OFF_CODE);
  assign is_note       = (event_kind == KIND_ON) || (event_kind == KIND_OFF);
  assign start         = in_take && (byte_position == POS_VEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_STATUS;
      event_kind    <= KIND_OTHER;
      event_channel <= '0;
      event_key     <= '0;
    end else if (in_take) begin
      case (byte_position)
        POS_STATUS: begin
          // Non-note status is skipped in mapping mode, kept as "other" otherwise.
          if (is_on_status || is_off_status || !mapping_mode) begin
            event_kind    <= is_on_status ? KIND_ON :
                             (is_off_status ? KIND_OFF : KIND_OTHER);
            event_channel <= midi_byte[3:0];
            byte_position <= POS_KEY;
          end
        end
        POS_KEY: begin
          event_key     <= is_note ? {1'b0, midi_byte[6:0]} : MOTOR_OFF;
          byte_position <= POS_VEL;
        end
        POS_VEL: byte_position <= POS_STATUS;
        default: byte_position <= POS_STATUS;
      endcase
    end
  end

  // Event summary for the walk; channels 8..15 match no motor.
  always_comb begin
    evt.mapping = mapping_mode;
    evt.kind    = event_kind;
    evt.vel_nz  = is_note && (midi_byte[6:0] != 7'd0);
    evt.key     = event_key;
    evt.pitch   = event_key - {1'b0, pitch_offset};
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      evt.match[i] = is_note && !event_channel[3] &&
                     (channel_map[3*i +: 3] == event_channel[2:0]);
    end
  end

  mnva_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .evt         (evt),
    .busy        (eng_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .motor_pitch (motor_pitch),
    .motor_index (motor_index),
    .last_update (last_update)
  );

endmodule
